/* hw/rtl/pselr_pkg.sv */
package pselr_pkg;

   localparam int MAX_MARKERS = 64;
   localparam int IDX_W       = $clog2(MAX_MARKERS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int COORD_W     = 16;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int SQ_W        = 2 * COORD_W;
   localparam int LIM_W       = 33;
   localparam int CHORD_W     = 34;
   localparam int CHORD_DEPTH = MAX_MARKERS - 1;

   // purpose of a marker store read
   typedef enum logic [1:0] {
      RD_CHORD,
      RD_COMPACT,
      RD_EMIT
   } rd_mode_type;

   // controller to datapath
   typedef struct packed {
      logic              rd_en;
      rd_mode_type       rd_mode;
      logic [IDX_W-1:0]  rd_addr;
      logic              rd_keep;
      logic [IDX_W-1:0]  rd_waddr;
      logic              rd_last;
      logic              ld_we;
      logic [IDX_W-1:0]  ld_addr;
      logic [IDX_W-1:0]  crd_addr;
      logic              cap_m1;
      logic              cap_0;
   } pselr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic busy;
      logic out_valid;
      logic rd_lt;
      logic c0_lt;
      logic nb_le;
   } pselr_status_type;

endpackage

/* hw/rtl/pselr_if.sv */
interface pselr_req_if import pselr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic                      last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface pselr_rsp_if import pselr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [IDX_W-1:0]          kept_index;
   logic signed [COORD_W-1:0] kept_x;
   logic signed [COORD_W-1:0] kept_y;
   logic                      end_of_list;

   modport source (output valid, kept_index, kept_x, kept_y, end_of_list, input ready);
   modport sink (input valid, kept_index, kept_x, kept_y, end_of_list, output ready);
endinterface

/* hw/rtl/pselr_ram.sv */
module pselr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write one entry, read one entry registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/pselr_datapath.sv */
module pselr_datapath import pselr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  pselr_cmd_type             cmd,
   output pselr_status_type          status,
   input  logic                      csr_we,
   input  logic [LIM_W-1:0]          csr_wdata,
   input  logic signed [COORD_W-1:0] in_x,
   input  logic signed [COORD_W-1:0] in_y,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [IDX_W-1:0]          out_index,
   output logic signed [COORD_W-1:0] out_x,
   output logic signed [COORD_W-1:0] out_y,
   output logic                      out_last
);

   logic [LIM_W-1:0]   lim_ff;
   logic [CHORD_W-1:0] lim_ext;

   // marker stores
   logic               m_we;
   logic [IDX_W-1:0]   m_waddr;
   logic [COORD_W-1:0] wx, wy, rx, ry;
   logic [IDX_W-1:0]   widx, ridx;

   // read tag stage
   logic               s1_vld_ff;
   rd_mode_type        s1_mode_ff;
   logic [IDX_W-1:0]   s1_k_ff;
   logic               s1_keep_ff;
   logic [IDX_W-1:0]   s1_w_ff;
   logic               s1_last_ff;

   // chord pipeline
   logic [COORD_W-1:0]       prev_x_ff, prev_y_ff;
   logic                     d_vld_ff, d_vld_in;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic [IDX_W-1:0]         d_addr_ff;
   logic                     q_vld_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic [IDX_W-1:0]         q_addr_ff;
   logic signed [2*DIFF_W-1:0] px, py;
   logic [CHORD_W-1:0]       c_wdata, c_rdata;
   logic [CHORD_W-1:0]       cm1_ff, c0_ff;

   // output register
   logic                      out_valid_ff;
   logic [IDX_W-1:0]          out_index_ff;
   logic [COORD_W-1:0]        out_x_ff, out_y_ff;
   logic                      out_last_ff;

   // hold the minimum chord register
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= '0;
      end else if (csr_we) begin
         lim_ff <= csr_wdata;
      end
   end

   assign lim_ext = {1'b0, lim_ff};

   // select load or compaction write
   always_comb begin
      m_we    = cmd.ld_we || (s1_vld_ff && s1_mode_ff == RD_COMPACT && s1_keep_ff);
      m_waddr = cmd.ld_we ? cmd.ld_addr : s1_w_ff;
      wx      = cmd.ld_we ? in_x : rx;
      wy      = cmd.ld_we ? in_y : ry;
      widx    = cmd.ld_we ? cmd.ld_addr : ridx;
   end

   pselr_ram #(.WIDTH(COORD_W), .DEPTH(MAX_MARKERS)) u_x_ram (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(wx),
      .raddr(cmd.rd_addr), .rdata(rx));

   pselr_ram #(.WIDTH(COORD_W), .DEPTH(MAX_MARKERS)) u_y_ram (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(wy),
      .raddr(cmd.rd_addr), .rdata(ry));

   pselr_ram #(.WIDTH(IDX_W), .DEPTH(MAX_MARKERS)) u_idx_ram (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(widx),
      .raddr(cmd.rd_addr), .rdata(ridx));

   pselr_ram #(.WIDTH(CHORD_W), .DEPTH(CHORD_DEPTH)) u_chord_ram (
      .clock(clock), .we(q_vld_ff), .waddr(q_addr_ff), .wdata(c_wdata),
      .raddr(cmd.crd_addr), .rdata(c_rdata));

   assign d_vld_in = s1_vld_ff && s1_mode_ff == RD_CHORD && s1_k_ff != '0;
   assign px       = dx_ff * dx_ff;
   assign py       = dy_ff * dy_ff;
   assign c_wdata  = CHORD_W'(sqx_ff) + CHORD_W'(sqy_ff);

   // control flops of the read tag and chord pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         d_vld_ff  <= 1'b0;
         q_vld_ff  <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.rd_en;
         d_vld_ff  <= d_vld_in;
         q_vld_ff  <= d_vld_ff;
      end
   end

   // advance the read tag, differences and squares
   always_ff @(posedge clock) begin
      s1_mode_ff <= cmd.rd_mode;
      s1_k_ff    <= cmd.rd_addr;
      s1_keep_ff <= cmd.rd_keep;
      s1_w_ff    <= cmd.rd_waddr;
      s1_last_ff <= cmd.rd_last;
      if (s1_vld_ff && s1_mode_ff == RD_CHORD) begin
         prev_x_ff <= rx;
         prev_y_ff <= ry;
      end
      dx_ff     <= $signed({rx[COORD_W-1], rx}) - $signed({prev_x_ff[COORD_W-1], prev_x_ff});
      dy_ff     <= $signed({ry[COORD_W-1], ry}) - $signed({prev_y_ff[COORD_W-1], prev_y_ff});
      d_addr_ff <= s1_k_ff - IDX_W'(1);
      sqx_ff    <= px[SQ_W-1:0];
      sqy_ff    <= py[SQ_W-1:0];
      q_addr_ff <= d_addr_ff;
      if (cmd.cap_m1) begin
         cm1_ff <= c_rdata;
      end
      if (cmd.cap_0) begin
         c0_ff <= c_rdata;
      end
   end

   // hold a result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_vld_ff && s1_mode_ff == RD_EMIT) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff && s1_mode_ff == RD_EMIT) begin
         out_index_ff <= ridx;
         out_x_ff     <= rx;
         out_y_ff     <= ry;
         out_last_ff  <= s1_last_ff;
      end
   end

   always_comb begin
      status.busy      = s1_vld_ff || d_vld_ff || q_vld_ff;
      status.out_valid = out_valid_ff;
      status.rd_lt     = c_rdata < lim_ext;
      status.c0_lt     = c0_ff < lim_ext;
      status.nb_le     = cm1_ff <= c_rdata;
   end

   assign out_valid = out_valid_ff;
   assign out_index = out_index_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_last  = out_last_ff;

endmodule

/* hw/rtl/pselr_ctrl.sv */
module pselr_ctrl import pselr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   input  pselr_status_type status,
   output pselr_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_LOAD, S_PSTART, S_CH_RD, S_CH_WAIT, S_D0_RD, S_D0_EV, S_LOOP,
      S_RA, S_RB, S_RC, S_EV, S_TAIL, S_T_EV, S_CP_RD, S_CP_WAIT,
      S_E_RD, S_E_LD
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       n_ff, k_ff, i_ff, w_ff;
   logic                   pre_ff;
   logic [MAX_MARKERS-1:0] drop_ff;
   logic [CNT_W:0]         i_p2;

   assign i_p2      = {1'b0, i_ff} + (CNT_W+1)'(2);
   assign req_ready = state_ff == S_LOAD;

   // drive datapath commands from state and counters
   always_comb begin
      cmd          = '0;
      cmd.rd_mode  = RD_CHORD;
      cmd.rd_addr  = k_ff[IDX_W-1:0];
      cmd.rd_keep  = !drop_ff[k_ff[IDX_W-1:0]];
      cmd.rd_waddr = w_ff[IDX_W-1:0];
      cmd.rd_last  = k_ff == n_ff - CNT_W'(1);
      cmd.ld_addr  = k_ff[IDX_W-1:0];
      cmd.crd_addr = i_ff[IDX_W-1:0];
      case (state_ff)
         S_LOAD:  cmd.ld_we = req_valid;
         S_CH_RD: cmd.rd_en = 1'b1;
         S_D0_RD: cmd.crd_addr = '0;
         S_RA:    cmd.crd_addr = i_ff[IDX_W-1:0] - IDX_W'(1);
         S_RB: begin
            cmd.cap_m1 = 1'b1;
         end
         S_RC: begin
            cmd.crd_addr = i_ff[IDX_W-1:0] + IDX_W'(1);
            cmd.cap_0    = 1'b1;
         end
         S_CP_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_mode = RD_COMPACT;
         end
         S_E_RD: begin
            cmd.rd_en   = !status.out_valid;
            cmd.rd_mode = RD_EMIT;
         end
         default: ;
      endcase
   end

   // sequence load, passes and emission
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         n_ff     <= '0;
         k_ff     <= '0;
         i_ff     <= '0;
         w_ff     <= '0;
         pre_ff   <= 1'b0;
         drop_ff  <= '0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (req_valid) begin
                  if (req_last || k_ff == CNT_W'(MAX_MARKERS - 1)) begin
                     n_ff     <= k_ff + CNT_W'(1);
                     k_ff     <= '0;
                     state_ff <= (k_ff + CNT_W'(1) < CNT_W'(3)) ? S_E_RD : S_PSTART;
                  end else begin
                     k_ff <= k_ff + CNT_W'(1);
                  end
               end
            end
            S_PSTART: begin
               k_ff     <= '0;
               w_ff     <= '0;
               drop_ff  <= '0;
               state_ff <= S_CH_RD;
            end
            S_CH_RD: begin
               k_ff <= k_ff + CNT_W'(1);
               if (k_ff == n_ff - CNT_W'(1)) begin
                  state_ff <= S_CH_WAIT;
               end
            end
            S_CH_WAIT: begin
               if (!status.busy) begin
                  state_ff <= S_D0_RD;
               end
            end
            S_D0_RD: state_ff <= S_D0_EV;
            // first chord decides whether marker one goes
            S_D0_EV: begin
               if (status.rd_lt) begin
                  pre_ff     <= 1'b1;
                  drop_ff[1] <= 1'b1;
                  i_ff       <= CNT_W'(2);
               end else begin
                  pre_ff <= 1'b0;
                  i_ff   <= CNT_W'(1);
               end
               state_ff <= S_LOOP;
            end
            S_LOOP: state_ff <= (i_p2 < {1'b0, n_ff}) ? S_RA : S_TAIL;
            S_RA: state_ff <= S_RB;
            S_RB: state_ff <= S_RC;
            S_RC: state_ff <= S_EV;
            // for a short chord, drop the endpoint with the shorter neighbor chord
            S_EV: begin
               if (!status.c0_lt) begin
                  pre_ff <= 1'b0;
                  i_ff   <= i_ff + CNT_W'(1);
               end else if (status.nb_le) begin
                  if (!pre_ff) begin
                     drop_ff[i_ff[IDX_W-1:0]] <= 1'b1;
                  end
                  pre_ff <= !pre_ff;
                  i_ff   <= i_ff + CNT_W'(1);
               end else begin
                  drop_ff[i_ff[IDX_W-1:0] + IDX_W'(1)] <= 1'b1;
                  pre_ff <= 1'b1;
                  i_ff   <= i_ff + CNT_W'(2);
               end
               state_ff <= S_LOOP;
            end
            S_TAIL: begin
               k_ff <= '0;
               w_ff <= '0;
               state_ff <= (i_ff + CNT_W'(1) != n_ff && !pre_ff) ? S_T_EV : S_CP_RD;
            end
            S_T_EV: begin
               if (status.rd_lt) begin
                  drop_ff[i_ff[IDX_W-1:0]] <= 1'b1;
               end
               state_ff <= S_CP_RD;
            end
            // copy survivors down in place
            S_CP_RD: begin
               k_ff <= k_ff + CNT_W'(1);
               if (!drop_ff[k_ff[IDX_W-1:0]]) begin
                  w_ff <= w_ff + CNT_W'(1);
               end
               if (k_ff == n_ff - CNT_W'(1)) begin
                  state_ff <= S_CP_WAIT;
               end
            end
            S_CP_WAIT: begin
               if (!status.busy) begin
                  n_ff <= w_ff;
                  k_ff <= '0;
                  state_ff <= (w_ff != n_ff && w_ff >= CNT_W'(3)) ? S_PSTART : S_E_RD;
               end
            end
            S_E_RD: begin
               if (!status.out_valid) begin
                  k_ff     <= k_ff + CNT_W'(1);
                  state_ff <= S_E_LD;
               end
            end
            S_E_LD: begin
               if (k_ff == n_ff) begin
                  k_ff     <= '0;
                  state_ff <= S_LOAD;
               end else begin
                  state_ff <= S_E_RD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

endmodule

/* hw/rtl/polyline_short_edge_removal_unit.sv */
// Channel   Dir  Handshake        Payload
// req_chan  in   valid/ready      point_x, point_y, last_point
// rsp_chan  out  valid/ready      kept_index, kept_x, kept_y, end_of_list
// csr       in   csr_write_en     csr_write_data (min_chord_len_sq)
//
// Loading accepts one point per cycle while req_ready is high. A pass over
// n markers makes at most n - 3 scan steps, whose chord reads share the
// single read port of the chord memory, plus one step when the last chord is
// checked. Emission reads a survivor only once the previous result is taken.
// Reset is synchronous and clears control and the threshold register only; no clearing pass is needed.
// A stalled result holds in the output register; loading of the next run
// starts while the final result of the previous run still waits.
module polyline_short_edge_removal_unit import pselr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   pselr_req_if.sink         req_chan,
   pselr_rsp_if.source       rsp_chan,
   input  logic              csr_write_en,
   input  logic [LIM_W-1:0]  csr_write_data
);

   pselr_cmd_type    cmd;
   pselr_status_type status;

   pselr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_point),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pselr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_write_en),
      .csr_wdata (csr_write_data),
      .in_x      (req_chan.point_x),
      .in_y      (req_chan.point_y),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_index (rsp_chan.kept_index),
      .out_x     (rsp_chan.kept_x),
      .out_y     (rsp_chan.kept_y),
      .out_last  (rsp_chan.end_of_list)
   );

endmodule

/* hw/rtl/pselr_checker.sv */
module pselr_checker import pselr_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_last_point,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [IDX_W-1:0]          rsp_kept_index,
   input logic signed [COORD_W-1:0] rsp_kept_x,
   input logic                      rsp_end_of_list
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kept_index) && $stable(rsp_kept_x))
      else $error("stalled result changed");

   // a closing request stops loading
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_point |=> !req_ready)
      else $error("request taken after closing marker");

   // no loading while a run is still being emitted
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_end_of_list |=> !req_ready)
      else $error("loading during emission");

   // only the final result may wait while loading
   assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_end_of_list)
      else $error("non-final result pending while loading");

endmodule

bind polyline_short_edge_removal_unit pselr_checker u_pselr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_last_point  (req_chan.last_point),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kept_index  (rsp_chan.kept_index),
   .rsp_kept_x      (rsp_chan.kept_x),
   .rsp_end_of_list (rsp_chan.end_of_list)
);

/* tb/sv/pselr_scoreboard.sv */
`timescale 1ns / 100ps

module pselr_scoreboard import pselr_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   pselr_req_if  req_chan,
   pselr_rsp_if  rsp_chan,
   input  logic  csr_write_en,
   input  logic  [LIM_W-1:0] csr_write_data,
   output int    fail_count,
   output int    kept_pending,
   output int    kept_seen
);

   typedef struct packed {
      logic [IDX_W-1:0]   index;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               eol;
   } kept_marker_type;

   kept_marker_type  kept_q[$];
   logic [COORD_W-1:0] mark_x[MAX_MARKERS];
   logic [COORD_W-1:0] mark_y[MAX_MARKERS];
   logic [IDX_W-1:0]   mark_idx[MAX_MARKERS];
   int               mark_cnt;
   longint           min_len_sq;

   // one thinning sweep over the live markers; returns 1 when any went away
   function automatic bit thin_sweep();
      longint chord[MAX_MARKERS];
      bit     drop[MAX_MARKERS];
      bit     pre;
      int     i, k, w, n;
      longint dx, dy;
      n = mark_cnt;
      if (n < 3) return 0;
      for (k = 0; k + 1 < n; k++) begin
         dx = longint'($signed(mark_x[k+1])) - longint'($signed(mark_x[k]));
         dy = longint'($signed(mark_y[k+1])) - longint'($signed(mark_y[k]));
         chord[k] = dx * dx + dy * dy;
      end
      for (k = 0; k < MAX_MARKERS; k++) drop[k] = 0;
      pre = 0;
      i = 1;
      if (chord[0] < min_len_sq) begin
         pre = 1;
         drop[1] = 1;
         i = 2;
      end
      while (i + 2 < n) begin
         if (chord[i] >= min_len_sq) begin
            pre = 0;
            i++;
         end else if (chord[i-1] <= chord[i+1]) begin
            if (!pre) begin
               drop[i] = 1;
               pre = 1;
            end else begin
               pre = 0;
            end
            i++;
         end else begin
            drop[i+1] = 1;
            pre = 1;
            i += 2;
         end
      end
      if (i + 1 != n && !pre && chord[i] < min_len_sq) drop[i] = 1;
      // compact survivors toward the front
      w = 0;
      for (k = 0; k < n; k++) begin
         if (!drop[k]) begin
            mark_x[w] = mark_x[k];
            mark_y[w] = mark_y[k];
            mark_idx[w] = mark_idx[k];
            w++;
         end
      end
      mark_cnt = w;
      return w != n;
   endfunction

   // thin until stable, then queue the survivors
   function automatic void predict_survivors();
      kept_marker_type m;
      int k;
      while (thin_sweep()) ;
      for (k = 0; k < mark_cnt; k++) begin
         m.index = mark_idx[k];
         m.x = mark_x[k];
         m.y = mark_y[k];
         m.eol = (k + 1 == mark_cnt);
         kept_q = {kept_q, m};
      end
      mark_cnt = 0;
   endfunction

   initial begin
      fail_count = 0;
      kept_seen = 0;
      kept_pending = 0;
      mark_cnt = 0;
      min_len_sq = 0;
   end

   always @(posedge clock) begin
      kept_marker_type exp_m;
      if (!reset) begin
         // track the threshold register
         if (csr_write_en) min_len_sq = longint'(csr_write_data);
         // load request, close the polyline on last point or full store
         if (req_chan.valid && req_chan.ready) begin
            mark_x[mark_cnt] = req_chan.point_x;
            mark_y[mark_cnt] = req_chan.point_y;
            mark_idx[mark_cnt] = mark_cnt[IDX_W-1:0];
            mark_cnt++;
            if (req_chan.last_point || mark_cnt == MAX_MARKERS) predict_survivors();
         end
         // compare each result with the oldest expectation
         if (rsp_chan.valid && rsp_chan.ready) begin
            kept_seen++;
            if (kept_q.size() == 0) begin
               $error("unexpected result: index %0d", rsp_chan.kept_index);
               fail_count++;
            end else begin
               exp_m = kept_q.pop_front();
               if (rsp_chan.kept_index !== exp_m.index) begin
                  $error("kept_index: expected %0d, actual %0d", exp_m.index,
                         rsp_chan.kept_index);
                  fail_count++;
               end
               if (rsp_chan.kept_x !== exp_m.x) begin
                  $error("kept_x: expected %0d, actual %0d", $signed(exp_m.x),
                         rsp_chan.kept_x);
                  fail_count++;
               end
               if (rsp_chan.kept_y !== exp_m.y) begin
                  $error("kept_y: expected %0d, actual %0d", $signed(exp_m.y),
                         rsp_chan.kept_y);
                  fail_count++;
               end
               if (rsp_chan.end_of_list !== exp_m.eol) begin
                  $error("end_of_list: expected %0d, actual %0d", exp_m.eol,
                         rsp_chan.end_of_list);
                  fail_count++;
               end
            end
         end
         kept_pending = kept_q.size();
      end
   end

endmodule

/* tb/sv/polyline_short_edge_removal_unit_tb.sv */
`timescale 1ns / 100ps

module polyline_short_edge_removal_unit_tb;
   import pselr_pkg::*;

   localparam longint LIM_MAX = 64'd8589672450;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [LIM_W-1:0] csr_write_data;
   int   fail_count;
   int   kept_pending;
   int   kept_seen;
   int   points_sent;
   int   runs_sent;
   int   lim_writes;
   bit   calm;
   bit   hold_rsp;

   pselr_req_if req_chan ();
   pselr_rsp_if rsp_chan ();

   polyline_short_edge_removal_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   pselr_scoreboard i_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .kept_pending   (kept_pending),
      .kept_seen      (kept_seen)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // abort a hung run
   initial begin
      #200_000_000;
      $display("status: fail");
      $finish;
   end

   // result side: random stall bursts, one long hold on request
   initial begin
      rsp_chan.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_chan.ready <= 0;
            repeat (900) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1;
         end
      end
   end

   // offer one marker, with an optional random gap first
   task automatic send_point(logic [15:0] px, logic [15:0] py, bit last);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.point_x <= px;
      req_chan.point_y <= py;
      req_chan.last_point <= last;
      do @(posedge clock); while (!req_chan.ready);
      points_sent++;
   endtask

   // wait for all results, then idle long enough for the block to settle
   task automatic drain_all();
      req_chan.valid <= 0;
      @(posedge clock);
      while (kept_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_min_len(longint v);
      drain_all();
      csr_write_en <= 1;
      csr_write_data <= v[LIM_W-1:0];
      @(posedge clock);
      csr_write_en <= 0;
      lim_writes++;
   endtask

   function automatic logic [15:0] clamp16(int v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // polyline: random walk (or raw random points), closed or open
   task automatic send_polyline(int n, bit closed, bit raw, bit with_last = 1);
      int cx, cy, stp, k;
      logic [15:0] fx, fy, px, py;
      cx = $signed($urandom_range(0, 65535) - 32768);
      cy = $signed($urandom_range(0, 65535) - 32768);
      case ($urandom_range(0, 3))
         0: stp = 3;
         1: stp = 30;
         2: stp = 300;
         default: stp = 3000;
      endcase
      for (k = 0; k < n; k++) begin
         if (raw) begin
            px = $urandom;
            py = $urandom;
         end else begin
            cx += $urandom_range(0, 2 * stp) - stp;
            cy += $urandom_range(0, 2 * stp) - stp;
            px = clamp16(cx);
            py = clamp16(cy);
         end
         if (k == 0) begin
            fx = px;
            fy = py;
         end
         if (closed && k == n - 1 && n > 1) begin
            px = fx;
            py = fy;
         end
         send_point(px, py, with_last && k == n - 1);
      end
      runs_sent++;
   endtask

   initial begin
      int j;
      longint pick;
      reset = 1;
      calm = 0;
      hold_rsp = 0;
      points_sent = 0;
      runs_sent = 0;
      lim_writes = 0;
      csr_write_en = 0;
      csr_write_data = '0;
      req_chan.valid = 0;
      req_chan.point_x = '0;
      req_chan.point_y = '0;
      req_chan.last_point = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // single and double marker polylines, nothing removable
      send_point(16'h0000, 16'h0000, 1);
      send_point(16'h7fff, 16'h8000, 0);
      send_point(16'h8000, 16'h7fff, 1);
      // zero threshold keeps everything, even repeated points
      send_point(16'h0005, 16'h0005, 0);
      send_point(16'h0005, 16'h0005, 0);
      send_point(16'h0005, 16'h0005, 1);
      // small square with short edges
      write_min_len(100);
      send_point(16'h0000, 16'h0000, 0);
      send_point(16'h0003, 16'h0000, 0);
      send_point(16'h0064, 16'h0000, 0);
      send_point(16'h0064, 16'h0002, 0);
      send_point(16'h0064, 16'h0064, 0);
      send_point(16'h0000, 16'h0000, 1);
      // corner extremes with the largest threshold
      write_min_len(LIM_MAX);
      send_point(16'h8000, 16'h8000, 0);
      send_point(16'h7fff, 16'h7fff, 0);
      send_point(16'h7fff, 16'h8000, 0);
      send_point(16'h8000, 16'h7fff, 0);
      send_point(16'h8000, 16'h8000, 1);
      // open polyline, last does not repeat first
      write_min_len(5000);
      send_point(16'h0000, 16'h0000, 0);
      send_point(16'h0010, 16'h0000, 0);
      send_point(16'h0020, 16'h0000, 0);
      send_point(16'h1000, 16'h1000, 1);
      runs_sent += 6;

      // random polylines, thresholds changed between runs
      j = 0;
      while (points_sent < 200) begin
         // no idling in the last part of the run
         if (points_sent > 150) calm = 1;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
               0: pick = 0;
               1: pick = LIM_MAX;
               2: pick = $urandom_range(1, 1000);
               3: pick = $urandom_range(1, 10_000_000);
               default: pick = {$urandom_range(0, 1), 32'($urandom)};
            endcase
            if (pick > LIM_MAX) pick = LIM_MAX;
            write_min_len(pick);
         end
         if (j == 3) begin
            // long result stall while markers keep coming
            hold_rsp = 1;
            send_polyline(8, 1, 0);
            send_polyline(10, 1, 0);
            send_polyline(6, 1, 0);
         end else if (j == 6 || j == 14) begin
            // store fills up without a closing marker
            send_polyline(MAX_MARKERS, 0, j == 14, 0);
         end else if (j == 10) begin
            send_polyline(MAX_MARKERS, 1, 0);
         end else begin
            send_polyline($urandom_range(1, 12), $urandom_range(0, 5) != 0,
                          $urandom_range(0, 4) == 0);
         end
         if (j == 8) drain_all();
         j++;
      end

      drain_all();
      $display("covered %0d markers in %0d polylines, %0d results, %0d threshold writes",
               points_sent, runs_sent, kept_seen, lim_writes);
      if (fail_count == 0 && kept_pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
